// ===== hdl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and coil tables for the stepper phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

   // field widths
   localparam int SPR_W  = 12;
   localparam int DEG_W  = 16;
   localparam int HOLD_W = 8;
   localparam int MODE_W = 2;
   localparam int IDX_W  = 3;
   localparam int COIL_W = 4;

   // default width of the step counter
   localparam int STEP_COUNT_WIDTH_DEF = 16;

   // angle times steps per rev, and the divide by 45 after the power of two shift
   localparam int PROD_W      = DEG_W + SPR_W;        // 28
   localparam int Y_W         = PROD_W - 2;           // 26, product / 4
   localparam int YH_W        = Y_W / 2;              // 13
   localparam int YL_W        = Y_W - YH_W;           // 13
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443718; // ceil(2^32 / 45)
   localparam int PP_HI_W     = YH_W + RECIP_W;
   localparam int PP_LO_W     = YL_W + RECIP_W;
   localparam int SUM_W       = Y_W + RECIP_W;        // 53
   localparam int QUOT_W      = 21;                   // largest quotient < 2^21

   // item kinds
   localparam logic KIND_MOVE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // mode codes, the high bit selects half step
   localparam logic [MODE_W-1:0] MODE_WAVE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HALF = 2'd2;

   // direction codes
   localparam logic DIR_FWD = 1'b0;
   localparam logic DIR_REV = 1'b1;

   // sequence index masks
   localparam logic [IDX_W-1:0] IDX_MASK_HALF = 3'd7;
   localparam logic [IDX_W-1:0] IDX_MASK_FULL = 3'd3;

   // payload carried down the arithmetic stages
   typedef struct packed {
      logic              kind;
      logic [MODE_W-1:0] mode;
      logic              dir;
      logic [HOLD_W-1:0] hold;
   } cmd_type;

   function automatic logic is_half(input logic [MODE_W-1:0] mode);
      is_half = mode[1];
   endfunction

   // coil pattern for a mode and sequence index
   function automatic logic [COIL_W-1:0] pattern_at(input logic [MODE_W-1:0] mode,
                                                    input logic [IDX_W-1:0]  idx);
      logic [COIL_W-1:0] pat;
      pat = 4'h0;
      if (is_half(mode)) begin
         case (idx)
            3'd0:    pat = 4'h2;
            3'd1:    pat = 4'h6;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h5;
            3'd4:    pat = 4'h1;
            3'd5:    pat = 4'h9;
            3'd6:    pat = 4'h8;
            default: pat = 4'hA;
         endcase
      end else if (mode == MODE_FULL) begin
         case (idx[1:0])
            2'd0:    pat = 4'h9;
            2'd1:    pat = 4'hA;
            2'd2:    pat = 4'h6;
            default: pat = 4'h5;
         endcase
      end else begin
         case (idx[1:0])
            2'd0:    pat = 4'h2;
            2'd1:    pat = 4'h4;
            2'd2:    pat = 4'h1;
            default: pat = 4'h8;
         endcase
      end
      pattern_at = pat;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/stepper_phase_sequencer.sv =====
// Each item passes the stage 1, stage 2 and stage 3 registers and then the result
// register before it can transfer.
// Throughput: one item per cycle unless a held result stalls it; the angle to step conversion is a 4 stage
// pipeline (multiply, split reciprocal multiply, sum, state update).
// A held result stalls the whole pipeline, so req_tready is low only while a result is held.
// Synchronous reset clears the pipeline, the motor state and steps_per_rev.
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Four coil stepper sequencer with wave, two-phase full and half step modes.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer
   import sps_pkg::*;
#(
   parameter int STEP_COUNT_WIDTH = STEP_COUNT_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // configuration
   input  wire logic             csr_wr_en,
   input  wire logic [SPR_W-1:0] csr_wr_data,  // steps_per_rev
   // commands and ticks
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [31:0]      req_tdata,    // mode[1:0], direction[2], degrees[18:3],
                                               // hold_ticks[26:19], zero fill
   input  wire logic             req_tuser,    // kind
   // results
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata     // coils[3:0], busy_res[4], done_res[5],
                                               // rejected[6], zero fill
);

   localparam int SW = STEP_COUNT_WIDTH;

   // steps_per_rev register
   logic [SPR_W-1:0] spr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff <= '0;
      end else if (csr_wr_en) begin
         spr_ff <= csr_wr_data;
      end
   end

   // pipeline advances when the result register is free or being drained
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // unpack input item
   cmd_type           in_cmd;
   logic [DEG_W-1:0]  in_deg;
   always_comb begin
      in_cmd.kind = req_tuser;
      in_cmd.mode = req_tdata[1:0];
      in_cmd.dir  = req_tdata[2];
      in_cmd.hold = req_tdata[26:19];
      in_deg      = req_tdata[18:3];
   end

   // stage 1: angle times steps per rev
   logic              v1_ff;
   cmd_type           c1_ff;
   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff   <= in_cmd;
         prod_ff <= PROD_W'(in_deg) * PROD_W'(spr_ff);
      end
   end

   // stage 2: divide by 8 or 4, then two partial products with 1/45
   logic              v2_ff;
   cmd_type           c2_ff;
   logic [Y_W-1:0]    y_val;
   logic [PP_HI_W-1:0] pp_hi_ff;
   logic [PP_LO_W-1:0] pp_lo_ff;

   assign y_val = is_half(c1_ff.mode) ? prod_ff[PROD_W-1:2]
                                      : {1'b0, prod_ff[PROD_W-1:3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c2_ff    <= c1_ff;
         pp_hi_ff <= PP_HI_W'(y_val[Y_W-1:YL_W]) * PP_HI_W'(RECIP_45);
         pp_lo_ff <= PP_LO_W'(y_val[YL_W-1:0]) * PP_LO_W'(RECIP_45);
      end
   end

   // stage 3: combine partial products, take quotient, saturate
   logic              v3_ff;
   cmd_type           c3_ff;
   logic [SUM_W-1:0]  sum_val;
   logic [QUOT_W-1:0] quot;
   logic [SW-1:0]     steps_sat;
   logic [SW-1:0]     steps3_ff;
   logic              zero3_ff;

   assign sum_val = {pp_hi_ff, {YL_W{1'b0}}} + SUM_W'(pp_lo_ff);
   assign quot    = sum_val[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];

   generate
      if (SW >= QUOT_W) begin : g_nosat
         assign steps_sat = SW'(quot);
      end else begin : g_sat
         assign steps_sat = (|quot[QUOT_W-1:SW]) ? {SW{1'b1}} : quot[SW-1:0];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c3_ff     <= c2_ff;
         steps3_ff <= steps_sat;
         zero3_ff  <= (quot == '0);
      end
   end

   // stage 4: motor state and result register
   logic [COIL_W-1:0] coil_ff, coil_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SW-1:0]     steps_left_ff, steps_left_in;
   logic [HOLD_W-1:0] hold_left_ff, hold_left_in;
   logic [HOLD_W-1:0] hold_reload_ff, hold_reload_in;
   logic [MODE_W-1:0] act_mode_ff, act_mode_in;
   logic              act_dir_ff, act_dir_in;
   logic              moving_ff, moving_in;
   logic              done_val, rej_val;
   logic [HOLD_W-1:0] hold_dec;
   logic [SW-1:0]     steps_dec;
   logic [IDX_W-1:0]  idx_mask;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_data_ff;

   assign hold_dec  = hold_left_ff - 1'b1;
   assign steps_dec = steps_left_ff - 1'b1;
   assign idx_mask  = is_half(act_mode_ff) ? IDX_MASK_HALF : IDX_MASK_FULL;

   // next state for one command or tick
   always_comb begin
      coil_in        = coil_ff;
      idx_in         = idx_ff;
      steps_left_in  = steps_left_ff;
      hold_left_in   = hold_left_ff;
      hold_reload_in = hold_reload_ff;
      act_mode_in    = act_mode_ff;
      act_dir_in     = act_dir_ff;
      moving_in      = moving_ff;
      done_val       = 1'b0;
      rej_val        = 1'b0;
      if (c3_ff.kind == KIND_MOVE) begin
         if (moving_ff) begin
            rej_val = 1'b1;
         end else if (zero3_ff) begin
            done_val = 1'b1;
         end else begin
            act_mode_in    = c3_ff.mode;
            act_dir_in     = c3_ff.dir;
            idx_in         = '0;
            coil_in        = pattern_at(c3_ff.mode, '0);
            steps_left_in  = steps3_ff;
            hold_reload_in = (c3_ff.hold == '0) ? HOLD_W'(1) : c3_ff.hold;
            hold_left_in   = (c3_ff.hold == '0) ? HOLD_W'(1) : c3_ff.hold;
            moving_in      = 1'b1;
         end
      end else if (moving_ff) begin
         hold_left_in = hold_dec;
         if (hold_dec == '0) begin
            steps_left_in = steps_dec;
            if (steps_dec == '0) begin
               moving_in = 1'b0;
               done_val  = 1'b1;
            end else begin
               if (act_dir_ff == DIR_REV) begin
                  idx_in = (idx_ff + idx_mask) & idx_mask;
               end else begin
                  idx_in = (idx_ff + 1'b1) & idx_mask;
               end
               coil_in      = pattern_at(act_mode_ff, idx_in);
               hold_left_in = hold_reload_ff;
            end
         end
      end
   end

   // state registers, updated only by an item leaving stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         coil_ff        <= '0;
         idx_ff         <= '0;
         steps_left_ff  <= '0;
         hold_left_ff   <= '0;
         hold_reload_ff <= '0;
         act_mode_ff    <= MODE_WAVE;
         act_dir_ff     <= DIR_FWD;
         moving_ff      <= 1'b0;
      end else if (advance && v3_ff) begin
         coil_ff        <= coil_in;
         idx_ff         <= idx_in;
         steps_left_ff  <= steps_left_in;
         hold_left_ff   <= hold_left_in;
         hold_reload_ff <= hold_reload_in;
         act_mode_ff    <= act_mode_in;
         act_dir_ff     <= act_dir_in;
         moving_ff      <= moving_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {1'b0, rej_val, done_val, moving_in, coil_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a finished move never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> !rsp_tdata[4])
      else $error("done reported while still busy");

   // a rejected command leaves the running move in place
   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> rsp_tdata[4] && !rsp_tdata[5])
      else $error("rejected command without a running move");

   // a running move always has steps and hold ticks left
   a_moving_counts: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (steps_left_ff != '0) && (hold_left_ff != '0)
                    && (hold_left_ff <= hold_reload_ff))
      else $error("move running with empty counters");

   // state only changes when an item leaves stage 3
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !($past(advance) && $past(v3_ff)) && !$past(reset)
         |-> $stable(moving_ff) && $stable(steps_left_ff) && $stable(coil_ff))
      else $error("motor state changed without an item");

endmodule

`default_nettype wire
